// ----- hdl/tsas_pkg.sv -----
// ----------------------------------------------------------------------------
// tsas_pkg
// shared types, widths and register codes for the touch average/scale block
// ----------------------------------------------------------------------------
package tsas_pkg;

	localparam int RAW_W     = 16;
	localparam int SHIFT     = 3;
	localparam int SUM_W     = 17;
	localparam int SIZE_W    = 12;
	localparam int PIX_W     = 13;
	localparam int CNT_W     = 4;
	localparam int PROD_W    = SUM_W + SIZE_W;
	localparam int RECIP_W   = 18;
	localparam int DIV_W     = 16;
	localparam int IDX_W     = 3;
	localparam int ADC_FULL  = 4095;
	localparam int SAMPLES_DEF = 15;

	localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(320);
	localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(240);

	typedef enum logic [IDX_W-1:0] {
		REG_SCREEN_WIDTH  = 3'd0,
		REG_SCREEN_HEIGHT = 3'd1,
		REG_SWAP_AXES     = 3'd2,
		REG_MIRROR_X      = 3'd3,
		REG_MIRROR_Y      = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic [SIZE_W-1:0] screen_width;
		logic [SIZE_W-1:0] screen_height;
		logic              swap_axes;
		logic              mirror_x;
		logic              mirror_y;
	} cfg_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} lane_ctl_t;

endpackage

// ----- hdl/tsas_lane.sv -----
// ----------------------------------------------------------------------------
// tsas_lane
// one axis: floor(sum * size / (SAMPLES * 4095)) by reciprocal multiply
// ----------------------------------------------------------------------------
module tsas_lane import tsas_pkg::*; #(
	parameter int SAMPLES = SAMPLES_DEF
) (
	input  logic              clk,
	input  lane_ctl_t         ctl,
	input  logic [SUM_W-1:0]  sum,
	input  logic [SIZE_W-1:0] size,
	output logic [PIX_W-1:0]  coord
);

	localparam int DIVISOR = SAMPLES * ADC_FULL;
	localparam logic [DIV_W-1:0] DIV_C = DIV_W'(DIVISOR);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << PROD_W) / DIVISOR);

	logic [PROD_W-1:0]         prod_s1;
	logic [PROD_W-1:0]         prod_s2;
	logic [PROD_W+RECIP_W-1:0] est_s2;
	logic [PROD_W-1:0]         prod_s3;
	logic [PIX_W-1:0]          quot_s3;
	logic [PROD_W-1:0]         back_s3;
	logic [PIX_W-1:0]          coord_s4;
	logic [PIX_W-1:0]          quot_est;
	logic [PROD_W-1:0]         rem;

	assign quot_est = est_s2[PROD_W +: PIX_W];
	assign rem      = prod_s3 - back_s3;

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			prod_s1 <= PROD_W'(sum) * PROD_W'(size);
		end
		if (ctl.en_s2) begin
			prod_s2 <= prod_s1;
			est_s2  <= (PROD_W+RECIP_W)'(prod_s1) * (PROD_W+RECIP_W)'(RECIP);
		end
		if (ctl.en_s3) begin
			prod_s3 <= prod_s2;
			quot_s3 <= quot_est;
			back_s3 <= PROD_W'(quot_est) * PROD_W'(DIV_C);
		end
		if (ctl.en_s4) begin
			// estimate is low by at most one
			coord_s4 <= quot_s3 + PIX_W'(rem >= PROD_W'(DIV_C));
		end
	end

	assign coord = coord_s4;

endmodule

// ----- hdl/tsas_merge.sv -----
// ----------------------------------------------------------------------------
// tsas_merge
// combines both lanes: mirror with clamp, result register and handshake
// ----------------------------------------------------------------------------
module tsas_merge import tsas_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  cfg_t             cfg,
	input  logic [PIX_W-1:0] lane_x,
	input  logic [PIX_W-1:0] lane_y,
	input  logic             coord_stall,
	output logic             coord_valid,
	output logic [PIX_W-1:0] x_pixel,
	output logic [PIX_W-1:0] y_pixel,
	output logic             mirror_clamped
);

	logic [PIX_W-1:0] width_ext;
	logic [PIX_W-1:0] height_ext;
	logic             x_under;
	logic             y_under;
	logic [PIX_W-1:0] x_res;
	logic [PIX_W-1:0] y_res;
	logic             clamp;
	logic             valid_q;

	assign width_ext  = PIX_W'(cfg.screen_width);
	assign height_ext = PIX_W'(cfg.screen_height);
	assign x_under    = lane_x > width_ext;
	assign y_under    = lane_y > height_ext;

	always_comb begin
		x_res = lane_x;
		y_res = lane_y;
		clamp = 1'b0;
		if (cfg.mirror_x) begin
			x_res = x_under ? '0 : width_ext - lane_x;
			clamp = x_under;
		end
		if (cfg.mirror_y) begin
			y_res = y_under ? '0 : height_ext - lane_y;
			clamp = clamp | y_under;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!coord_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_pixel        <= x_res;
			y_pixel        <= y_res;
			mirror_clamped <= clamp;
		end
	end

	assign coord_valid = valid_q;

endmodule

// ----- hdl/touch_sample_average_scale_top.sv -----
// ----------------------------------------------------------------------------
// touch_sample_average_scale_top
// averages raw touch converter words per axis and scales them to pixels
// ----------------------------------------------------------------------------
// a finished batch passes lane stages s1 to s4, then the result register
// one sample per cycle unless stalled, one result per SAMPLES samples
// each axis lane does the reciprocal multiply in 4 stages
// input stalls only while all four stages are full and the result is stalled
// reset: sums and sample count clear, registers return to 320/240/0/0/0
// ----------------------------------------------------------------------------
module touch_sample_average_scale_top import tsas_pkg::*; #(
	parameter int SAMPLES = SAMPLES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  logic [RAW_W-1:0]  raw_x_word,
	input  logic [RAW_W-1:0]  raw_y_word,
	output logic              coord_valid,
	input  logic              coord_stall,
	output logic [PIX_W-1:0]  x_pixel,
	output logic [PIX_W-1:0]  y_pixel,
	output logic              mirror_clamped,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [SIZE_W-1:0] cfg_data
);

	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES - 1);

	cfg_t             cfg_q;
	logic [SUM_W-1:0] x_sum_q;
	logic [SUM_W-1:0] y_sum_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] x_next;
	logic [SUM_W-1:0] y_next;
	logic             accept;
	logic             launch;
	logic             v_s1, v_s2, v_s3, v_s4;
	logic             rdy_out, rdy_s4, rdy_s3, rdy_s2, rdy_s1;
	lane_ctl_t        ctl;
	logic [PIX_W-1:0] coord_x;
	logic [PIX_W-1:0] coord_y;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= WIDTH_RST;
			cfg_q.screen_height <= HEIGHT_RST;
			cfg_q.swap_axes     <= 1'b0;
			cfg_q.mirror_x      <= 1'b0;
			cfg_q.mirror_y      <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data;
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data;
				REG_SWAP_AXES:     cfg_q.swap_axes     <= cfg_data[0];
				REG_MIRROR_X:      cfg_q.mirror_x      <= cfg_data[0];
				REG_MIRROR_Y:      cfg_q.mirror_y      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// pipeline flow control
	assign rdy_out = !coord_valid || !coord_stall;
	assign rdy_s4  = !v_s4 || rdy_out;
	assign rdy_s3  = !v_s3 || rdy_s4;
	assign rdy_s2  = !v_s2 || rdy_s3;
	assign rdy_s1  = !v_s1 || rdy_s2;

	assign sample_stall = !rdy_s1;
	assign accept       = sample_valid && !sample_stall;
	assign launch       = accept && (count_q == LAST_CNT);

	assign x_next = x_sum_q + SUM_W'(raw_x_word[RAW_W-1:SHIFT]);
	assign y_next = y_sum_q + SUM_W'(raw_y_word[RAW_W-1:SHIFT]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_sum_q <= '0;
			y_sum_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (launch) begin
				x_sum_q <= '0;
				y_sum_q <= '0;
				count_q <= '0;
			end else begin
				x_sum_q <= x_next;
				y_sum_q <= y_next;
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= launch;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	assign ctl.en_s1 = launch;
	assign ctl.en_s2 = v_s1 && rdy_s2;
	assign ctl.en_s3 = v_s2 && rdy_s3;
	assign ctl.en_s4 = v_s3 && rdy_s4;

	tsas_lane #(.SAMPLES(SAMPLES)) u_lane_x (
		.clk   (clk),
		.ctl   (ctl),
		.sum   (cfg_q.swap_axes ? y_next : x_next),
		.size  (cfg_q.screen_width),
		.coord (coord_x)
	);

	tsas_lane #(.SAMPLES(SAMPLES)) u_lane_y (
		.clk   (clk),
		.ctl   (ctl),
		.sum   (cfg_q.swap_axes ? x_next : y_next),
		.size  (cfg_q.screen_height),
		.coord (coord_y)
	);

	tsas_merge u_merge (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (v_s4 && rdy_out),
		.cfg            (cfg_q),
		.lane_x         (coord_x),
		.lane_y         (coord_y),
		.coord_stall    (coord_stall),
		.coord_valid    (coord_valid),
		.x_pixel        (x_pixel),
		.y_pixel        (y_pixel),
		.mirror_clamped (mirror_clamped)
	);

endmodule

// ----- hdl/tsas_checker.sv -----
// ----------------------------------------------------------------------------
// tsas_checker
// port-level checks for the touch average/scale block
// ----------------------------------------------------------------------------
module tsas_checker import tsas_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             sample_valid,
	input logic             sample_stall,
	input logic             coord_valid,
	input logic             coord_stall,
	input logic [PIX_W-1:0] x_pixel,
	input logic [PIX_W-1:0] y_pixel,
	input logic             mirror_clamped
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		coord_valid && coord_stall |=> coord_valid && $stable(x_pixel)
			&& $stable(y_pixel) && $stable(mirror_clamped))
		else $error("stalled result changed");

	// a clamp always leaves one coordinate at zero
	a_clamp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		coord_valid && mirror_clamped |-> x_pixel == '0 || y_pixel == '0)
		else $error("clamp flagged without a zero coordinate");

	// an empty result register never holds back samples
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!coord_valid |-> !sample_stall)
		else $error("sample stalled with output empty");

	// a result drained without stall frees the input side
	a_drain_frees: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && coord_valid && !coord_stall |-> !sample_stall)
		else $error("sample stalled while output drains");

endmodule

bind touch_sample_average_scale_top tsas_checker u_tsas_checker (.*);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// valid/stall driver and monitor against a shadow average and scale model
// ----------------------------------------------------------------------------
module testbench;
	import tsas_pkg::*;

	localparam int BATCH       = SAMPLES_DEF;
	localparam int SETTLE      = 12;
	localparam int HOLD_LEN    = 200;
	localparam int RAND_PHASES = 11;
	localparam int HOLD_PHASE  = 9;
	localparam int LIMIT_NS    = 400000;
	localparam logic [IDX_W-1:0] REG_UNUSED_FIRST = IDX_W'(REG_MIRROR_Y) + IDX_W'(1);

	typedef struct {
		logic [RAW_W-1:0] x_word;
		logic [RAW_W-1:0] y_word;
	} touch_t;

	typedef struct {
		logic [PIX_W-1:0] x_pix;
		logic [PIX_W-1:0] y_pix;
		logic             clamped;
	} coord_t;

	logic              clk            = 1'b0;
	logic              arst_n         = 1'b0;
	logic              sample_valid   = 1'b0;
	logic              sample_stall;
	logic [RAW_W-1:0]  raw_x_word     = '0;
	logic [RAW_W-1:0]  raw_y_word     = '0;
	logic              coord_valid;
	logic              coord_stall    = 1'b0;
	logic [PIX_W-1:0]  x_pixel;
	logic [PIX_W-1:0]  y_pixel;
	logic              mirror_clamped;
	logic              cfg_valid      = 1'b0;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index      = '0;
	logic [SIZE_W-1:0] cfg_data       = '0;

	touch_t touch_queue[$];
	coord_t expected_coords[$];
	touch_t next_touch;
	coord_t oldest_coord;

	cfg_t              cfg_shadow;
	logic [SUM_W-1:0]  x_acc;
	logic [SUM_W-1:0]  y_acc;
	logic [CNT_W-1:0]  acc_count;

	int tx_idle_pct = 17;
	int rx_idle_pct = 79;
	logic hold_go   = 1'b0;
	int hold_cnt    = 0;
	int err_count   = 0;

	touch_sample_average_scale_top #(
		.SAMPLES(BATCH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.raw_x_word(raw_x_word),
		.raw_y_word(raw_y_word),
		.coord_valid(coord_valid),
		.coord_stall(coord_stall),
		.x_pixel(x_pixel),
		.y_pixel(y_pixel),
		.mirror_clamped(mirror_clamped),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [PIX_W-1:0] scale_to_pixels(logic [SUM_W-1:0] sum,
			logic [SIZE_W-1:0] size);
		longint unsigned prod;
		prod = sum;
		prod = prod * size;
		return PIX_W'(prod / (BATCH * ADC_FULL));
	endfunction

	task automatic accumulate_touch(logic [RAW_W-1:0] xw, logic [RAW_W-1:0] yw);
		logic [SUM_W-1:0] x_src;
		logic [SUM_W-1:0] y_src;
		logic [PIX_W-1:0] xp;
		logic [PIX_W-1:0] yp;
		logic             clamp;
		x_acc = x_acc + SUM_W'(xw >> SHIFT);
		y_acc = y_acc + SUM_W'(yw >> SHIFT);
		acc_count = acc_count + CNT_W'(1);
		if (acc_count < CNT_W'(BATCH))
			return;
		x_src = cfg_shadow.swap_axes ? y_acc : x_acc;
		y_src = cfg_shadow.swap_axes ? x_acc : y_acc;
		xp = scale_to_pixels(x_src, cfg_shadow.screen_width);
		yp = scale_to_pixels(y_src, cfg_shadow.screen_height);
		clamp = 1'b0;
		if (cfg_shadow.mirror_x) begin
			if (xp > cfg_shadow.screen_width) begin
				clamp = 1'b1;
				xp = '0;
			end else begin
				xp = PIX_W'(cfg_shadow.screen_width) - xp;
			end
		end
		if (cfg_shadow.mirror_y) begin
			if (yp > cfg_shadow.screen_height) begin
				clamp = 1'b1;
				yp = '0;
			end else begin
				yp = PIX_W'(cfg_shadow.screen_height) - yp;
			end
		end
		expected_coords.push_back('{xp, yp, clamp});
		x_acc = '0;
		y_acc = '0;
		acc_count = '0;
	endtask

	// sample request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			raw_x_word <= '0;
			raw_y_word <= '0;
		end else begin
			if (sample_valid && !sample_stall)
				accumulate_touch(raw_x_word, raw_y_word);
			if (!sample_valid || !sample_stall) begin
				if (touch_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					next_touch = touch_queue.pop_front();
					sample_valid <= 1'b1;
					raw_x_word <= next_touch.x_word;
					raw_y_word <= next_touch.y_word;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// coordinate monitor and output stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_stall <= 1'b0;
		end else begin
			if (coord_valid && !coord_stall) begin
				if (expected_coords.size() == 0) begin
					$display("%0t: unexpected coordinate x=%0d y=%0d clamp=%0d",
						$time, x_pixel, y_pixel, mirror_clamped);
					err_count++;
				end else begin
					oldest_coord = expected_coords.pop_front();
					if (x_pixel !== oldest_coord.x_pix) begin
						$display("%0t: x_pixel expected %0d actual %0d",
							$time, oldest_coord.x_pix, x_pixel);
						err_count++;
					end
					if (y_pixel !== oldest_coord.y_pix) begin
						$display("%0t: y_pixel expected %0d actual %0d",
							$time, oldest_coord.y_pix, y_pixel);
						err_count++;
					end
					if (mirror_clamped !== oldest_coord.clamped) begin
						$display("%0t: mirror_clamped expected %0d actual %0d",
							$time, oldest_coord.clamped, mirror_clamped);
						err_count++;
					end
				end
			end
			if (hold_go && hold_cnt < HOLD_LEN) begin
				hold_cnt <= hold_cnt + 1;
				coord_stall <= 1'b1;
			end else begin
				coord_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_SCREEN_WIDTH:  cfg_shadow.screen_width = data;
			REG_SCREEN_HEIGHT: cfg_shadow.screen_height = data;
			REG_SWAP_AXES:     cfg_shadow.swap_axes = data[0];
			REG_MIRROR_X:      cfg_shadow.mirror_x = data[0];
			REG_MIRROR_Y:      cfg_shadow.mirror_y = data[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h, logic sw,
			logic mx, logic my);
		write_reg(REG_SCREEN_WIDTH, w);
		write_reg(REG_SCREEN_HEIGHT, h);
		write_reg(REG_SWAP_AXES, SIZE_W'(sw));
		write_reg(REG_MIRROR_X, SIZE_W'(mx));
		write_reg(REG_MIRROR_Y, SIZE_W'(my));
	endtask

	// wait until every queued sample is taken and every coordinate is back
	task automatic drain();
		while (touch_queue.size() != 0 || sample_valid)
			@(negedge clk);
		while (expected_coords.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic push_batch(logic [RAW_W-1:0] xw, logic [RAW_W-1:0] yw);
		repeat (BATCH) touch_queue.push_back('{xw, yw});
	endtask

	function automatic logic [RAW_W-1:0] rand_word();
		logic [11:0] adc;
		adc = 12'($urandom_range(4095));
		case ($urandom_range(9))
			7, 8: return RAW_W'($urandom);
			9: return $urandom_range(1) ? '1 : '0;
			default: return {1'b0, adc, 3'($urandom)};
		endcase
	endfunction

	function automatic logic [SIZE_W-1:0] rand_size();
		case ($urandom_range(7))
			0: return SIZE_W'(1);
			1: return SIZE_W'(ADC_FULL);
			default: return SIZE_W'($urandom_range(1, ADC_FULL));
		endcase
	endfunction

	initial begin
		int n;
		cfg_shadow = '{WIDTH_RST, HEIGHT_RST, 1'b0, 1'b0, 1'b0};
		x_acc = '0;
		y_acc = '0;
		acc_count = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// writes to unused indexes must leave the reset sizes alone
		for (int i = REG_UNUSED_FIRST; i < 2 ** IDX_W; i++)
			write_reg(IDX_W'(i), '0);
		push_batch('1, '1);
		drain();

		// swapped and mirrored with both edges of the clamp
		write_all(SIZE_W'(ADC_FULL), SIZE_W'(1), 1'b1, 1'b1, 1'b1);
		push_batch('1, {1'b0, 12'hFFF, 3'b000});
		drain();

		// zero width, untouched low bits
		write_all('0, SIZE_W'(ADC_FULL), 1'b0, 1'b0, 1'b1);
		push_batch('0, RAW_W'(7));
		drain();

		for (int p = 0; p < RAND_PHASES; p++) begin
			if (p < 4) begin
				tx_idle_pct = 17;
				rx_idle_pct = 79;
			end else if (p < 8) begin
				tx_idle_pct = 79;
				rx_idle_pct = 17;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			write_all(rand_size(), rand_size(), 1'($urandom), 1'($urandom), 1'($urandom));
			n = BATCH * $urandom_range(2, 5) + $urandom_range(0, BATCH - 1);
			if (p == HOLD_PHASE) begin
				n = BATCH * 10;
				@(posedge clk);
				hold_go <= 1'b1;
			end
			repeat (n) touch_queue.push_back('{rand_word(), rand_word()});
			drain();
		end

		if (err_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/tsas_pkg.sv
hdl/tsas_lane.sv
hdl/tsas_merge.sv
hdl/touch_sample_average_scale_top.sv
hdl/tsas_checker.sv
test/testbench.sv
